// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by three of the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ttbc_pkg.sv =====
`timescale 1ns / 1ps
package ttbc_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_COMPASS_ENABLE = 1'b0;
  localparam logic REG_HEADING_REF    = 1'b1;

  // Beeper mask when no beep is running.
  localparam logic [15:0] BEEP_MASK_IDLE = 16'hFFFF;

  // Heading arithmetic: ((540 + width - reference) mod 360) - 180.
  localparam logic [12:0] HEAD_BIAS   = 13'd540;
  localparam logic [12:0] DEG_FULL    = 13'd360;
  localparam logic [8:0]  DEG_HALF    = 9'd180;
  // floor(2^17 / 360); the quotient estimate is exact or one low below 8192.
  localparam logic [8:0]  RECIP_360   = 9'd364;
  localparam int          RECIP_SHIFT = 17;

  typedef struct packed {
    logic        enable;
    logic [8:0]  reference;
  } cfg_t;

  typedef struct packed {
    logic        compass_level;
    logic        load_beep;
    logic [15:0] beep_duration;
    logic [15:0] beep_pattern;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] millisecond_count;
    logic        motor_update;
    logic        beeper_on;
  } timebase_res_t;

  typedef struct packed {
    logic [11:0]        compass_width;
    logic signed [8:0]  heading_offset;
  } compass_res_t;

endpackage

// ===== hw/rtl/ttbc_if.sv =====
`timescale 1ns / 1ps
// Tick input channel.
interface ttbc_in_if;
  logic        valid;
  logic        ready;
  logic        compass_level;
  logic        load_beep;
  logic [15:0] beep_duration;
  logic [15:0] beep_pattern;

  modport source (output valid, compass_level, load_beep, beep_duration, beep_pattern,
                  input ready);
  modport sink (input valid, compass_level, load_beep, beep_duration, beep_pattern,
                output ready);
endinterface

// Result output channel.
interface ttbc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        millisecond_count;
  logic               motor_update;
  logic               beeper_on;
  logic [11:0]        compass_width;
  logic signed [8:0]  heading_offset;

  modport source (output valid, millisecond_count, motor_update, beeper_on, compass_width,
                  heading_offset, input ready);
  modport sink (input valid, millisecond_count, motor_update, beeper_on, compass_width,
                heading_offset, output ready);
endinterface

// ===== hw/rtl/ttbc_regs.sv =====
`timescale 1ns / 1ps
module ttbc_regs
  import ttbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b0;
      cfg.reference <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_COMPASS_ENABLE: cfg.enable    <= pwdata[0];
        REG_HEADING_REF:    cfg.reference <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_index)
      REG_COMPASS_ENABLE: prdata = {31'd0, cfg.enable};
      REG_HEADING_REF:    prdata = {23'd0, cfg.reference};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ttbc_timebase.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttbc_timebase
  import ttbc_pkg::*;
#(
  parameter int TICKS_PER_MS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          commit,
  input  tick_item_t    item,
  output timebase_res_t res
);

  localparam int DIV_W = (TICKS_PER_MS > 2) ? $clog2(TICKS_PER_MS) : 1;
  localparam logic [DIV_W-1:0] DIV_RELOAD = DIV_W'(TICKS_PER_MS - 1);

  logic [DIV_W-1:0] tick_divider, tick_divider_next;
  logic             motor_phase, motor_phase_next;
  logic [15:0]      ms_counter, ms_counter_next;
  logic [15:0]      beep_remaining, beep_remaining_next;
  logic [15:0]      beep_mask, beep_mask_next;
  logic [15:0]      rem_loaded, mask_loaded;
  logic             beep_on;

  // Prescaler: fires on the first tick and then once per millisecond.
  always_comb begin
    if (tick_divider == '0) begin
      tick_divider_next = DIV_RELOAD;
      motor_phase_next  = ~motor_phase;
      ms_counter_next   = ms_counter + 16'd1;
    end else begin
      tick_divider_next = tick_divider - DIV_W'(1);
      motor_phase_next  = motor_phase;
      ms_counter_next   = ms_counter;
    end
  end

  // Beeper: optional load, then count down and gate with the pattern.
  always_comb begin
    rem_loaded  = item.load_beep ? item.beep_duration : beep_remaining;
    mask_loaded = item.load_beep ? item.beep_pattern  : beep_mask;
    if (rem_loaded > 16'd1) begin
      beep_remaining_next = rem_loaded - 16'd1;
      beep_mask_next      = mask_loaded;
      beep_on             = |(beep_remaining_next & mask_loaded);
    end else begin
      beep_remaining_next = rem_loaded;
      beep_mask_next      = BEEP_MASK_IDLE;
      beep_on             = 1'b0;
    end
  end

  assign res.millisecond_count = ms_counter_next;
  assign res.motor_update      = (tick_divider == '0) && motor_phase;
  assign res.beeper_on         = beep_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider   <= '0;
      motor_phase    <= 1'b1;
      ms_counter     <= '0;
      beep_remaining <= '0;
      beep_mask      <= BEEP_MASK_IDLE;
    end else if (commit) begin
      tick_divider   <= tick_divider_next;
      motor_phase    <= motor_phase_next;
      ms_counter     <= ms_counter_next;
      beep_remaining <= beep_remaining_next;
      beep_mask      <= beep_mask_next;
    end
  end

  // A motor pulse always coincides with a millisecond step.
  `ASSERT_NEXT(a_motor_ms_step, clk, rst, commit && res.motor_update,
               ms_counter == $past(ms_counter) + 16'd1 && !motor_phase,
               "motor update without millisecond step")

endmodule

// ===== hw/rtl/ttbc_compass.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttbc_compass
  import ttbc_pkg::*;
#(
  parameter int WIDTH_LIMIT = 4000
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         commit,
  input  cfg_t         cfg,
  input  logic         level,
  output compass_res_t res
);

  logic [15:0]       pulse_counter, pulse_counter_next;
  logic [11:0]       kept_width, kept_width_next;
  logic signed [8:0] heading_register, heading_next;
  logic              width_ok;
  logic [12:0]       head_sum;
  logic [21:0]       head_prod;
  logic [3:0]        head_quot;
  logic [12:0]       head_rem0, head_rem;

  assign width_ok = (pulse_counter != '0) && (pulse_counter < 16'(WIDTH_LIMIT));

  // Width capture on the low level.
  always_comb begin
    pulse_counter_next = pulse_counter;
    kept_width_next    = kept_width;
    if (cfg.enable) begin
      if (level) begin
        pulse_counter_next = pulse_counter + 16'd1;
      end else begin
        pulse_counter_next = '0;
        if (width_ok) begin
          kept_width_next = pulse_counter[11:0];
        end
      end
    end
  end

  // Heading: reciprocal multiply for mod 360, then one correction step.
  always_comb begin
    head_sum  = HEAD_BIAS + 13'(kept_width_next) - 13'(cfg.reference);
    head_prod = 22'(head_sum) * 22'(RECIP_360);
    head_quot = head_prod[RECIP_SHIFT+3:RECIP_SHIFT];
    head_rem0 = head_sum - 13'(head_quot) * DEG_FULL;
    head_rem  = (head_rem0 >= DEG_FULL) ? head_rem0 - DEG_FULL : head_rem0;
    if (cfg.enable && !level) begin
      heading_next = $signed(head_rem[8:0] - DEG_HALF);
    end else begin
      heading_next = heading_register;
    end
  end

  assign res.compass_width  = kept_width_next;
  assign res.heading_offset = heading_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counter    <= '0;
      kept_width       <= '0;
      heading_register <= '0;
    end else if (commit) begin
      pulse_counter    <= pulse_counter_next;
      kept_width       <= kept_width_next;
      heading_register <= heading_next;
    end
  end

  // A low tick while enabled always clears the pulse counter.
  `ASSERT_NEXT(a_low_clears, clk, rst, commit && cfg.enable && !level,
               pulse_counter == '0, "pulse counter not cleared on low level")
  // Capture state holds while disabled.
  `ASSERT_NEXT(a_disabled_hold, clk, rst, commit && !cfg.enable,
               $stable(kept_width) && $stable(heading_register) && $stable(pulse_counter),
               "compass state changed while disabled")
  // Heading stays in its range.
  `ASSERT_ALWAYS(a_heading_range, clk, rst,
                 heading_register >= -9'sd180 && heading_register <= 9'sd179,
                 "heading out of range")

endmodule

// ===== hw/rtl/tick_timebase_beeper_compass.sv =====
// Tick timebase, beeper and compass capture.
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle while the output is ready; an input register and a
// result register allow one more item to be taken while a result waits on the output.
// Reset (rst, synchronous, active high) clears all state and the valid flags of both registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tick_timebase_beeper_compass
  import ttbc_pkg::*;
#(
  parameter int TICKS_PER_MS = 10,
  parameter int WIDTH_LIMIT  = 4000
) (
  input  logic        clk,
  input  logic        rst,
  ttbc_in_if.sink     tick,
  ttbc_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t          cfg;
  tick_item_t    item;
  logic          item_valid;
  logic          advance;
  timebase_res_t tb_res;
  compass_res_t  cp_res;

  ttbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held item moves on when the result register is free or draining.
  assign advance    = item_valid && (!result.valid || result.ready);
  assign tick.ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      item.compass_level <= tick.compass_level;
      item.load_beep     <= tick.load_beep;
      item.beep_duration <= tick.beep_duration;
      item.beep_pattern  <= tick.beep_pattern;
    end
  end

  ttbc_timebase #(
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_timebase (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (item),
    .res    (tb_res)
  );

  ttbc_compass #(
    .WIDTH_LIMIT (WIDTH_LIMIT)
  ) u_compass (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .cfg    (cfg),
    .level  (item.compass_level),
    .res    (cp_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.millisecond_count <= tb_res.millisecond_count;
      result.motor_update      <= tb_res.motor_update;
      result.beeper_on         <= tb_res.beeper_on;
      result.compass_width     <= cp_res.compass_width;
      result.heading_offset    <= cp_res.heading_offset;
    end
  end

  // Both stages full with the output stalled: no further item is taken.
  `ASSERT_ALWAYS(a_full_stall, clk, rst,
                 !(item_valid && result.valid && !result.ready) || !tick.ready,
                 "item accepted while pipeline full and stalled")
  // A drained result with nothing behind it leaves the output empty.
  `ASSERT_NEXT(a_drain_empty, clk, rst, result.valid && result.ready && !item_valid,
               !result.valid, "result repeated after drain")

endmodule

// ===== verif/tick_timebase_beeper_compass_test.sv =====
`timescale 1ns / 1ps
module tick_timebase_beeper_compass_test
  import ttbc_pkg::*;
();

  localparam int TICKS_PER_MS = 10;
  localparam int WIDTH_LIMIT  = 4000;

  typedef struct packed {
    logic [15:0]       millisecond_count;
    logic              motor_update;
    logic              beeper_on;
    logic [11:0]       compass_width;
    logic signed [8:0] heading_offset;
  } tick_result_t;

  typedef struct packed {
    tick_item_t item;
    logic       drain;
  } pending_tick_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Driven values, all known from time zero.
  logic        drv_valid = 1'b0;
  tick_item_t  drv_tick  = '0;
  logic        mon_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  ttbc_in_if  tick_ch ();
  ttbc_out_if result_ch ();

  assign tick_ch.valid         = drv_valid;
  assign tick_ch.compass_level = drv_tick.compass_level;
  assign tick_ch.load_beep     = drv_tick.load_beep;
  assign tick_ch.beep_duration = drv_tick.beep_duration;
  assign tick_ch.beep_pattern  = drv_tick.beep_pattern;
  assign result_ch.ready       = mon_ready;

  tick_timebase_beeper_compass #(
    .TICKS_PER_MS(TICKS_PER_MS),
    .WIDTH_LIMIT (WIDTH_LIMIT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow of the block's configuration and state, starting from reset values.
  cfg_t        cfg_model     = '0;
  logic [3:0]  div_count     = '0;
  logic        phase_bit     = 1'b1;
  logic [15:0] ms_model      = '0;
  logic [15:0] beep_left     = '0;
  logic [15:0] beep_gate     = BEEP_MASK_IDLE;
  logic [15:0] pulse_len     = '0;
  logic [11:0] width_model   = '0;
  logic [8:0]  heading_model = '0;

  pending_tick_t pending_ticks[$];
  tick_result_t  expected_results[$];

  int send_idle_pct    = 17;
  int recv_idle_pct    = 56;
  int ticks_queued     = 0;
  int results_checked  = 0;
  int motor_seen       = 0;
  int beeps_seen       = 0;
  int settings_written = 0;
  int mismatches       = 0;

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               field, results_checked, got, want);
    end
  endtask

  // Advances the shadow state by one tick and returns the result it should give.
  function automatic tick_result_t advance_timebase(tick_item_t t);
    tick_result_t r;
    int           turn;
    r = '0;
    // Prescaler, millisecond counter and motor phase.
    if (div_count == 4'd0) begin
      div_count = 4'(TICKS_PER_MS - 1);
      phase_bit = ~phase_bit;
      r.motor_update = ~phase_bit;
      ms_model = ms_model + 16'd1;
    end else begin
      div_count = div_count - 4'd1;
    end
    // Beeper countdown, gated by the pattern.
    if (t.load_beep) begin
      beep_left = t.beep_duration;
      beep_gate = t.beep_pattern;
    end
    if (beep_left > 16'd1) begin
      beep_left = beep_left - 16'd1;
      r.beeper_on = |(beep_left & beep_gate);
    end else begin
      beep_gate = BEEP_MASK_IDLE;
    end
    // Compass pulse capture and heading on each low tick.
    if (cfg_model.enable) begin
      if (t.compass_level) begin
        pulse_len = pulse_len + 16'd1;
      end else begin
        if (pulse_len != 16'd0 && pulse_len < 16'(WIDTH_LIMIT)) begin
          width_model = pulse_len[11:0];
        end
        turn = (int'(HEAD_BIAS) + int'(width_model) - int'(cfg_model.reference))
               % int'(DEG_FULL) - int'(DEG_HALF);
        heading_model = 9'(turn);
        pulse_len = '0;
      end
    end
    r.millisecond_count = ms_model;
    r.compass_width     = width_model;
    r.heading_offset    = heading_model;
    return r;
  endfunction

  function automatic tick_item_t make_tick(logic level, logic load, logic [15:0] duration,
                                           logic [15:0] pattern);
    tick_item_t t;
    t.compass_level = level;
    t.load_beep     = load;
    t.beep_duration = duration;
    t.beep_pattern  = pattern;
    return t;
  endfunction

  // Random beeper content; loads are rare and mostly short so beeps finish.
  function automatic tick_item_t random_tick(logic level);
    tick_item_t t;
    t.compass_level = level;
    t.load_beep     = ($urandom_range(11) == 0);
    t.beep_duration = (t.load_beep && $urandom_range(2) != 0) ?
                      16'($urandom_range(40)) : 16'($urandom);
    t.beep_pattern  = 16'($urandom);
    return t;
  endfunction

  task automatic queue_tick(input tick_item_t t, input logic drain);
    pending_ticks.push_back('{item: t, drain: drain});
    ticks_queued++;
  endtask

  task automatic queue_pulse(input int high_len, input int low_len);
    repeat (high_len) queue_tick(random_tick(1'b1), 1'b0);
    repeat (low_len) queue_tick(random_tick(1'b0), 1'b0);
  endtask

  // Mostly well-formed compass pulses, with some stray levels and empty pulses.
  task automatic queue_random_ticks(input int count);
    int start;
    start = ticks_queued;
    queue_tick(random_tick(1'($urandom_range(1))), 1'b1);
    while (ticks_queued - start < count) begin
      case ($urandom_range(9))
        0: queue_tick(random_tick(1'($urandom_range(1))), 1'($urandom_range(29) == 0));
        1: queue_pulse(0, $urandom_range(1, 3));
        default: queue_pulse($urandom_range(1, 40), $urandom_range(1, 4));
      endcase
    end
  endtask

  // Waits until every queued item has been taken and every result has come back.
  task automatic settle();
    while (pending_ticks.size() != 0 || drv_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes one register, reads it back and updates the shadow configuration.
  task automatic program_register(input logic idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_COMPASS_ENABLE) ? 32'h1 : 32'h1FF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    pwdata  <= 32'($urandom);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      report_mismatch("register read-back", int'(prdata & mask), int'(value & mask));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_COMPASS_ENABLE) begin
      cfg_model.enable = value[0];
    end else begin
      cfg_model.reference = value[8:0];
    end
    settings_written++;
  endtask

  // Driver: presents queued items, idles at random and holds an item until taken.
  always @(posedge clk) begin : tick_driver
    pending_tick_t head;
    logic          hold;
    logic [63:0]   noise;
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && tick_ch.ready) begin
        expected_results.push_back(advance_timebase(drv_tick));
      end
      if (!drv_valid || tick_ch.ready) begin
        hold = (pending_ticks.size() == 0) || ($urandom_range(99) < send_idle_pct);
        if (!hold && pending_ticks[0].drain && expected_results.size() != 0) begin
          hold = 1'b1;
        end
        if (hold) begin
          noise = {$urandom, $urandom};
          drv_valid <= 1'b0;
          drv_tick  <= noise[33:0];
        end else begin
          head = pending_ticks.pop_front();
          drv_valid <= 1'b1;
          drv_tick  <= head.item;
        end
      end
    end
  end

  // Monitor: compares each result taken with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    tick_result_t want;
    if (rst) begin
      mon_ready <= 1'b0;
    end else begin
      if (result_ch.valid && mon_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_ch.millisecond_count !== want.millisecond_count) begin
            report_mismatch("millisecond_count", int'(result_ch.millisecond_count),
                            int'(want.millisecond_count));
          end
          if (result_ch.motor_update !== want.motor_update) begin
            report_mismatch("motor_update", int'(result_ch.motor_update),
                            int'(want.motor_update));
          end
          if (result_ch.beeper_on !== want.beeper_on) begin
            report_mismatch("beeper_on", int'(result_ch.beeper_on), int'(want.beeper_on));
          end
          if (result_ch.compass_width !== want.compass_width) begin
            report_mismatch("compass_width", int'(result_ch.compass_width),
                            int'(want.compass_width));
          end
          if (result_ch.heading_offset !== want.heading_offset) begin
            report_mismatch("heading_offset", int'(result_ch.heading_offset),
                            int'(want.heading_offset));
          end
          if (want.motor_update) motor_seen++;
          if (want.beeper_on) beeps_seen++;
        end
        results_checked++;
      end
      mon_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Beeper corners with the compass still disabled; the first tick fires the prescaler.
    queue_tick(make_tick(1'b1, 1'b0, 16'h0000, 16'h0000), 1'b0);
    queue_tick(make_tick(1'b0, 1'b1, 16'hFFFF, 16'hFFFF), 1'b0);
    queue_tick(make_tick(1'b1, 1'b1, 16'h0000, 16'h0000), 1'b0);
    queue_tick(make_tick(1'b1, 1'b1, 16'h0001, 16'hFFFF), 1'b0);
    queue_tick(make_tick(1'b0, 1'b1, 16'h0003, 16'h0001), 1'b0);
    queue_tick(make_tick(1'b0, 1'b0, 16'hFFFF, 16'hFFFF), 1'b0);
    queue_tick(make_tick(1'b0, 1'b0, 16'h0000, 16'h0000), 1'b0);
    queue_tick(make_tick(1'b0, 1'b1, 16'h0005, 16'h0000), 1'b0);
    queue_tick(make_tick(1'b1, 1'b0, 16'h0000, 16'h0000), 1'b0);
    settle();

    // Compass enabled, zero reference: empty pulse, widths of one and three.
    program_register(REG_COMPASS_ENABLE, {31'($urandom), 1'b1});
    program_register(REG_HEADING_REF, 32'd0);
    queue_pulse(0, 1);
    queue_pulse(1, 1);
    queue_pulse(3, 2);
    settle();

    // Largest in-range reference, then a reference beyond a full turn.
    program_register(REG_HEADING_REF, {23'($urandom), 9'd359});
    queue_pulse(1, 1);
    settle();
    program_register(REG_HEADING_REF, {23'($urandom), 9'd511});
    queue_pulse(0, 1);
    queue_pulse(2, 1);

    // Random phases: sender idles lightly, then heavily, then not at all.
    for (int p = 0; p < 3; p++) begin
      settle();
      send_idle_pct = (p == 0) ? 17 : (p == 1) ? 56 : 0;
      recv_idle_pct = (p == 0) ? 56 : (p == 1) ? 17 : 0;
      program_register(REG_COMPASS_ENABLE, {31'($urandom), 1'($urandom_range(3) != 0)});
      program_register(REG_HEADING_REF, {23'($urandom), 9'($urandom_range(511))});
      queue_random_ticks(200);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d tick results across %0d register writes and three idling regimes,",
             results_checked, settings_written);
    $display("with %0d motor pulses and %0d beeper-on ticks.",
             motor_seen, beeps_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin : watchdog
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
